### src/fixed_point_to_lcd_text_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FIXED_POINT_TO_LCD_TEXT_MACROS_SVH
`define FIXED_POINT_TO_LCD_TEXT_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define FTL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fixed_point_to_lcd_text: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define FTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fixed_point_to_lcd_text: next-cycle check failed");
`else
`define FTL_ASSERT_SAME(label, ante, cons)
`define FTL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/ftl_pkg.sv
package ftl_pkg;

    // Default and upper bound of the decimal field width.
    localparam int MAX_DIGITS_DEF = 5;

    // Field widths of the streams and the configuration port.
    localparam int ROW_W    = 3;
    localparam int COL_W    = 5;
    localparam int VALUE_W  = 16;
    localparam int S_DATA_W = 24;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 3;
    localparam int CFG_IDX_W = 1;
    // Compare width for clamping the register values (holds up to fifteen).
    localparam int CLAMP_W  = 4;
    // Bit counter of the serial conversion: one magnitude bit per cycle.
    localparam int BIT_CNT_W = $clog2(VALUE_W);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INT_DIGITS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_DIGITS = 1'b1;

    // Register reset values.
    localparam logic [CFG_W-1:0] INT_DIGITS_RST  = 3'd3;
    localparam logic [CFG_W-1:0] FRAC_DIGITS_RST = 3'd0;

    // Display codes.
    localparam logic [BYTE_W-1:0] SET_ADDR_CMD = 8'h80;
    localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_POINT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_BLANK   = 8'h20;
    localparam logic [3:0]        DIGIT_ZONE   = 4'h3;

    // DDRAM offsets of the four rows.
    localparam logic [BYTE_W-1:0] ROW1_BASE = 8'h00;
    localparam logic [BYTE_W-1:0] ROW2_BASE = 8'h40;
    localparam logic [BYTE_W-1:0] ROW3_BASE = 8'h14;
    localparam logic [BYTE_W-1:0] ROW4_BASE = 8'h54;

    // What the converter hands to the character sequencer besides the digits.
    typedef struct packed {
        logic [BYTE_W-1:0] addr_cmd;
        logic              negative;
    } ftl_num_t;

    // Set-address instruction for a row and column; rows out of range use row one.
    function automatic logic [BYTE_W-1:0] addr_cmd(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] column);
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] sum;
        unique case (row)
            3'd2:    base = ROW2_BASE;
            3'd3:    base = ROW3_BASE;
            3'd4:    base = ROW4_BASE;
            default: base = ROW1_BASE;
        endcase
        sum = base + {{(BYTE_W-COL_W){1'b0}}, column} - 8'd1;
        return sum | SET_ADDR_CMD;
    endfunction

endpackage

### src/ftl_bcd.sv
module ftl_bcd #(
    parameter int MAX_DIGITS = ftl_pkg::MAX_DIGITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ftl_pkg::ROW_W-1:0]        row,
    input  logic [ftl_pkg::COL_W-1:0]        column,
    input  logic signed [ftl_pkg::VALUE_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_take,
    output ftl_pkg::ftl_num_t                out_num,
    output logic [4*MAX_DIGITS-1:0]          out_digits
);
    import ftl_pkg::*;

    localparam int DW = 4 * MAX_DIGITS;

    logic                 busy_reg, busy_next;
    logic                 full_reg, full_next;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic [VALUE_W-1:0]   mag_reg;
    logic [DW-1:0]        bcd_reg;
    logic [DW-1:0]        bcd_adj;
    logic [DW-1:0]        bcd_next;
    ftl_num_t             num_reg;
    logic                 accept;
    logic                 last_bit;

    assign in_ready   = !busy_reg && !full_reg;
    assign accept     = in_valid && in_ready;
    assign last_bit   = (cnt_reg == '0);
    assign out_valid  = full_reg;
    assign out_num    = num_reg;
    assign out_digits = bcd_reg;

    // Shift-and-add-three: each digit of five or more is corrected before the shift.
    always_comb
    begin
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
        // The carry out of the top digit is dropped, which keeps the value modulo 10^n.
        bcd_next = {bcd_adj[DW-2:0], mag_reg[VALUE_W-1]};
    end

    // Control: busy while bits are shifted in, full until the sequencer takes the number.
    always_comb
    begin
        busy_next = busy_reg;
        full_next = full_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && last_bit)
        begin
            busy_next = 1'b0;
            full_next = 1'b1;
        end
        else if (full_reg && out_take)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            full_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            full_reg <= full_next;
            if (accept)
            begin
                cnt_reg <= BIT_CNT_W'(VALUE_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Payload: magnitude shifts out from the top, digits build up one bit a cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
            bcd_reg <= '0;
            num_reg.addr_cmd <= addr_cmd(row, column);
            num_reg.negative <= value[VALUE_W-1];
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= bcd_next;
        end
    end

endmodule

### src/ftl_emit.sv
module ftl_emit #(
    parameter int MAX_DIGITS = ftl_pkg::MAX_DIGITS_DEF,
    parameter int CW = $clog2(MAX_DIGITS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [CW-1:0]               ni,
    input  logic [CW-1:0]               nf,
    input  logic                        num_valid,
    output logic                        num_take,
    input  ftl_pkg::ftl_num_t           num,
    input  logic [4*MAX_DIGITS-1:0]     digits,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ftl_pkg::BYTE_W-1:0]  m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);
    import ftl_pkg::*;

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMD  = 3'd1;
    localparam logic [2:0] ST_INT  = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_DOT  = 3'd4;
    localparam logic [2:0] ST_FRAC = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [IW-1:0]           j_reg, j_next;
    logic                    zero_reg, zero_next;
    logic                    valid_reg, valid_next;
    logic [BYTE_W-1:0]       byte_reg, byte_next;
    logic                    cmd_reg, cmd_next;
    logic                    last_reg, last_next;
    logic [4*MAX_DIGITS-1:0] digits_reg;
    ftl_num_t                num_reg;
    logic                    advance;
    logic [3:0]              cur_digit;
    logic [BYTE_W-1:0]       cur_char;
    logic [BYTE_W-1:0]       sign_char;
    logic                    int_last;
    logic [CW:0]             n_sum;

    assign advance   = !valid_reg || m_tready;
    assign num_take  = (state_reg == ST_IDLE) && num_valid;
    assign cur_digit = digits_reg[4*j_reg +: 4];
    assign cur_char  = {DIGIT_ZONE, cur_digit};
    assign sign_char = num_reg.negative ? CHAR_MINUS : CHAR_BLANK;
    assign int_last  = (j_reg == IW'(nf));
    assign n_sum     = {1'b0, ni} + {1'b0, nf};

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = cmd_reg;
    assign m_tlast  = last_reg;

    // Character sequencer: one transfer per step; j indexes the digits from the top down.
    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        zero_next  = zero_reg;
        valid_next = valid_reg && !m_tready;
        byte_next  = byte_reg;
        cmd_next   = cmd_reg;
        last_next  = last_reg;
        if (num_take)
        begin
            state_next = ST_CMD;
        end
        else if (advance && state_reg != ST_IDLE)
        begin
            valid_next = 1'b1;
            cmd_next   = 1'b0;
            last_next  = 1'b0;
            unique case (state_reg)
                ST_CMD:
                begin
                    byte_next  = num_reg.addr_cmd;
                    cmd_next   = 1'b1;
                    j_next     = IW'(n_sum - 1'b1);
                    zero_next  = 1'b1;
                    state_next = ST_INT;
                end
                ST_INT:
                begin
                    if (zero_reg && (cur_digit != 4'd0 || int_last))
                    begin
                        // Sign goes just before the first significant digit.
                        byte_next  = sign_char;
                        state_next = ST_SIGN;
                    end
                    else if (!zero_reg)
                    begin
                        byte_next = cur_char;
                        if (int_last)
                        begin
                            last_next  = (nf == '0);
                            state_next = (nf == '0) ? ST_IDLE : ST_DOT;
                        end
                        else
                        begin
                            j_next = j_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        // Leading zero shown as a blank.
                        byte_next = CHAR_BLANK;
                        j_next    = j_reg - 1'b1;
                    end
                end
                ST_SIGN:
                begin
                    byte_next = cur_char;
                    zero_next = 1'b0;
                    if (int_last)
                    begin
                        last_next  = (nf == '0);
                        state_next = (nf == '0) ? ST_IDLE : ST_DOT;
                    end
                    else
                    begin
                        j_next     = j_reg - 1'b1;
                        state_next = ST_INT;
                    end
                end
                ST_DOT:
                begin
                    byte_next  = CHAR_POINT;
                    j_next     = j_reg - 1'b1;
                    state_next = ST_FRAC;
                end
                ST_FRAC:
                begin
                    byte_next = cur_char;
                    if (j_reg == '0)
                    begin
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next = j_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers of the sequencer and the output stage.
    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        zero_reg <= zero_next;
        byte_reg <= byte_next;
        cmd_reg  <= cmd_next;
        last_reg <= last_next;
        if (num_take)
        begin
            digits_reg <= digits;
            num_reg    <= num;
        end
    end

endmodule

### src/fixed_point_to_lcd_text.sv
// The set-address byte leaves once the converter has handed on the number, the characters
// follow one per cycle while m_tready is high (up to eight transfers per number).
// The bit-serial binary-to-decimal loop takes one of the 16 magnitude bits per cycle and
// overlaps the character output; a new number is taken once the previous one is handed on.
// Reset (rst_n, asynchronous, active low) empties both stages and sets int_digits to 3
// and frac_digits to 0.
module fixed_point_to_lcd_text #(
    parameter int MAX_DIGITS = ftl_pkg::MAX_DIGITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // row [2:0], column [7:3], value [23:8]
    input  logic [ftl_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_byte [7:0]
    output logic [ftl_pkg::BYTE_W-1:0]     m_tdata,
    // is_command [0]
    output logic                           m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [ftl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ftl_pkg::CFG_W-1:0]      cfg_data
);
    import ftl_pkg::*;
    `include "fixed_point_to_lcd_text_macros.svh"

    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic [CFG_W-1:0]        int_digits_reg;
    logic [CFG_W-1:0]        frac_digits_reg;
    logic [CLAMP_W-1:0]      ni_w;
    logic [CLAMP_W-1:0]      nf_w;
    logic [CLAMP_W-1:0]      room_w;
    logic [CW-1:0]           ni;
    logic [CW-1:0]           nf;
    logic                    num_valid;
    logic                    num_take;
    ftl_num_t                num;
    logic [4*MAX_DIGITS-1:0] digits;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_digits_reg  <= INT_DIGITS_RST;
            frac_digits_reg <= FRAC_DIGITS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INT_DIGITS:  int_digits_reg  <= cfg_data;
                REG_FRAC_DIGITS: frac_digits_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Clamp the integer width to 1..MAX_DIGITS and the fraction width to what remains.
    always_comb
    begin
        if (int_digits_reg == '0)
        begin
            ni_w = CLAMP_W'(1);
        end
        else if ({1'b0, int_digits_reg} > CLAMP_W'(MAX_DIGITS))
        begin
            ni_w = CLAMP_W'(MAX_DIGITS);
        end
        else
        begin
            ni_w = {1'b0, int_digits_reg};
        end
        room_w = CLAMP_W'(MAX_DIGITS) - ni_w;
        nf_w   = ({1'b0, frac_digits_reg} > room_w) ? room_w : {1'b0, frac_digits_reg};
    end

    assign ni = CW'(ni_w);
    assign nf = CW'(nf_w);

    ftl_bcd #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_bcd (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .row        (s_tdata[ROW_W-1:0]),
        .column     (s_tdata[ROW_W+COL_W-1:ROW_W]),
        .value      (s_tdata[ROW_W+COL_W+VALUE_W-1:ROW_W+COL_W]),
        .out_valid  (num_valid),
        .out_take   (num_take),
        .out_num    (num),
        .out_digits (digits)
    );

    ftl_emit #(
        .MAX_DIGITS (MAX_DIGITS),
        .CW         (CW)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ni         (ni),
        .nf         (nf),
        .num_valid  (num_valid),
        .num_take   (num_take),
        .num        (num),
        .digits     (digits),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // The converter takes one number at a time.
    `FTL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    // A set-address instruction always carries the command bit and never closes a number.
    `FTL_ASSERT_SAME(a_cmd_form, m_tvalid && m_tuser, m_tdata[7] && !m_tlast)
    // Characters are digits, blanks, signs or points, all below 0x40.
    `FTL_ASSERT_SAME(a_char_range, m_tvalid && !m_tuser, m_tdata[7:6] == 2'b00)
    // The sequencer takes each handed-over number only once.
    `FTL_ASSERT_NEXT(a_take_once, num_take, !num_take)

endmodule

### tb/sv/lcd_text_tb_pkg.sv
`timescale 1ns / 1ps

package lcd_text_tb_pkg;

    import ftl_pkg::*;

    // One byte towards the display, as the output stream carries it.
    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              is_command;
        logic              last;
    } lcd_byte_t;

    // Predicts the display bytes of every accepted number and checks the output stream.
    class display_text_ledger;

        lcd_byte_t        expected_bytes[$];
        logic [CFG_W-1:0] int_reg;
        logic [CFG_W-1:0] frac_reg;
        int               mismatches;

        function new();
            int_reg    = INT_DIGITS_RST;
            frac_reg   = FRAC_DIGITS_RST;
            mismatches = 0;
        endfunction

        // Mirror of a register write on the configuration port.
        function void write_reg(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] data);
            if (index == REG_INT_DIGITS)
            begin
                int_reg = data;
            end
            else if (index == REG_FRAC_DIGITS)
            begin
                frac_reg = data;
            end
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= 40)
            begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endtask

        // Works out the set-address byte and the characters of one accepted number.
        function void note_number(input logic [ROW_W-1:0] row,
                                  input logic [COL_W-1:0] column,
                                  input logic [VALUE_W-1:0] value);
            int                int_width;
            int                frac_width;
            int                total;
            int                magnitude;
            logic [3:0]        digit[MAX_DIGITS_DEF];
            logic [BYTE_W-1:0] base;
            logic [BYTE_W-1:0] addr;
            logic [BYTE_W-1:0] sign_char;
            logic [BYTE_W-1:0] text[$];
            bit                leading;

            // Clamp the widths the way the block does.
            int_width = int_reg;
            if (int_width < 1)
            begin
                int_width = 1;
            end
            if (int_width > MAX_DIGITS_DEF)
            begin
                int_width = MAX_DIGITS_DEF;
            end
            frac_width = frac_reg;
            if (frac_width > MAX_DIGITS_DEF - int_width)
            begin
                frac_width = MAX_DIGITS_DEF - int_width;
            end
            total = int_width + frac_width;

            // The magnitude of the most negative value is 32768.
            magnitude = value[VALUE_W-1] ? 65536 - int'(value) : int'(value);
            sign_char = value[VALUE_W-1] ? CHAR_MINUS : CHAR_BLANK;
            for (int i = total - 1; i >= 0; i--)
            begin
                digit[i]  = 4'(magnitude % 10);
                magnitude = magnitude / 10;
            end

            // Rows out of range fall back to the first row; the sum wraps at eight bits.
            case (row)
                3'd2:    base = ROW2_BASE;
                3'd3:    base = ROW3_BASE;
                3'd4:    base = ROW4_BASE;
                default: base = ROW1_BASE;
            endcase
            addr = base + {3'b000, column} - 8'd1;
            addr = addr | SET_ADDR_CMD;

            // Leading zeros become blanks; the sign sits just before the first digit shown.
            leading = 1'b1;
            for (int i = 0; i < int_width - 1; i++)
            begin
                if (leading && digit[i] != 4'd0)
                begin
                    leading = 1'b0;
                    text.push_back(sign_char);
                    text.push_back({DIGIT_ZONE, digit[i]});
                end
                else if (!leading)
                begin
                    text.push_back({DIGIT_ZONE, digit[i]});
                end
                else
                begin
                    text.push_back(CHAR_BLANK);
                end
            end
            if (leading)
            begin
                text.push_back(sign_char);
            end
            text.push_back({DIGIT_ZONE, digit[int_width-1]});
            if (frac_width > 0)
            begin
                text.push_back(CHAR_POINT);
                for (int i = int_width; i < total; i++)
                begin
                    text.push_back({DIGIT_ZONE, digit[i]});
                end
            end

            expected_bytes.push_back('{addr, 1'b1, 1'b0});
            foreach (text[i])
            begin
                expected_bytes.push_back('{text[i], 1'b0, i == text.size() - 1});
            end
        endfunction

        // Compares one output transfer with the oldest expected byte.
        task check_byte(input logic [BYTE_W-1:0] code, input logic is_command,
                        input logic last);
            lcd_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("byte %h with nothing expected", code));
                return;
            end
            want = expected_bytes.pop_front();
            if (code !== want.code)
            begin
                report_mismatch($sformatf("byte %h, expected %h", code, want.code));
            end
            if (is_command !== want.is_command)
            begin
                report_mismatch($sformatf("command flag %b, expected %b on byte %h",
                                          is_command, want.is_command, want.code));
            end
            if (last !== want.last)
            begin
                report_mismatch($sformatf("last flag %b, expected %b on byte %h",
                                          last, want.last, want.code));
            end
        endtask

        function int waiting();
            return expected_bytes.size();
        endfunction

        task check_drained();
            if (expected_bytes.size() != 0)
            begin
                report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
            end
        endtask

    endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import ftl_pkg::*;
    import lcd_text_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 50;
    localparam int PHASES       = 11;
    localparam int PHASE_ITEMS  = 40;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BYTE_W-1:0]    m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    display_text_ledger ledger;
    int                 cycles = 0;
    int                 burst_left = 0;
    bit                 gaps_on = 1'b1;
    bit                 hold_request = 1'b0;

    fixed_point_to_lcd_text dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Every output transfer is checked against the prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            ledger.check_byte(m_tdata, m_tuser, m_tlast);
        end
    end

    // The receiver switches between stall patterns and honours one long hold-off.
    initial
    begin : receiver
        int segment;
        int mode;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            segment = $urandom_range(20, 200);
            mode    = $urandom_range(0, 3);
            repeat (segment)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    m_tready     = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(0, 1));
                    2:       m_tready = ($urandom_range(0, 4) != 0);
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Register write, only issued while the block is idle.
    task automatic write_setting(input logic [CFG_IDX_W-1:0] index,
                                 input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        ledger.write_reg(index, data);
    endtask

    // Offers one number; the sender works in bursts with random gaps between them.
    task automatic offer_number(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column,
                                input logic [VALUE_W-1:0] value);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, ($urandom_range(0, 5) == 0) ? 40 : 15) : 0;
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = {value, column, row};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        ledger.note_number(row, column, value);
        burst_left--;
    endtask

    // Stops offering and waits until every predicted byte has been transferred.
    task automatic drain_output();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (ledger.waiting() > 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int power;
        int near;
        case ($urandom_range(0, 7))
            0: return VALUE_W'($urandom_range(0, 9));
            1: return VALUE_W'($urandom_range(0, 999));
            2: return VALUE_W'(-int'($urandom_range(0, 999)));
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'hFFFF;
                    3:       return 16'h0000;
                    default: return 16'h0001;
                endcase
            end
            4:
            begin
                // Values around a power of ten exercise digit roll-over and truncation.
                power = 1;
                repeat ($urandom_range(1, 4)) power = power * 10;
                near = power + int'($urandom_range(0, 2)) - 1;
                return $urandom_range(0, 1) ? VALUE_W'(-near) : VALUE_W'(near);
            end
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    task automatic offer_random_number();
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        row    = ($urandom_range(0, 4) != 0) ? ROW_W'($urandom_range(1, 4))
                                             : ROW_W'($urandom_range(0, 7));
        column = ($urandom_range(0, 4) != 0) ? COL_W'($urandom_range(1, 20))
                                             : COL_W'($urandom_range(0, 31));
        offer_number(row, column, pick_value());
    endtask

    initial
    begin : stimulus
        int int_setting[PHASES];
        int frac_setting[PHASES];

        int_setting  = '{5, 1, 2, 0, 7, 4, 5, 1, 3, 6, 2};
        frac_setting = '{0, 4, 3, 2, 7, 1, 4, 0, 2, 5, 6};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_INT_DIGITS;
        cfg_data  = '0;
        ledger    = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed numbers under the reset widths: extremes, row and column corners.
        offer_number(3'd1, 5'd1,  16'h0000);
        offer_number(3'd4, 5'd20, 16'h7FFF);
        offer_number(3'd2, 5'd20, 16'h8000);
        offer_number(3'd3, 5'd1,  16'hFFFF);
        offer_number(3'd1, 5'd0,  16'd5);
        offer_number(3'd0, 5'd10, 16'(-7));
        offer_number(3'd5, 5'd31, 16'd100);
        offer_number(3'd6, 5'd15, 16'(-100));
        offer_number(3'd7, 5'd2,  16'd999);
        offer_number(3'd4, 5'd1,  16'd1000);
        offer_number(3'd2, 5'd5,  16'(-12345));
        offer_number(3'd3, 5'd19, 16'd10);
        offer_number(3'd1, 5'd20, 16'(-9));
        offer_number(3'd2, 5'd1,  16'h5555);
        offer_number(3'd3, 5'd3,  16'hAAAA);
        offer_number(3'd4, 5'd4,  16'(-1000));
        offer_number(3'd2, 5'd0,  16'd1);
        offer_number(3'd0, 5'd0,  16'(-1001));
        offer_number(3'd4, 5'd31, 16'd12000);
        offer_number(3'd1, 5'd16, 16'd505);
        repeat (16) offer_random_number();
        drain_output();

        // Random numbers under a sequence of width settings, out-of-range ones included.
        for (int p = 0; p < PHASES; p++)
        begin
            write_setting(REG_INT_DIGITS, CFG_W'(int_setting[p]));
            write_setting(REG_FRAC_DIGITS, CFG_W'(frac_setting[p]));
            gaps_on = (p % 3 != 1);
            if (p == 2)
            begin
                // Back-pressure: the output stops for a long while and the input backs up.
                gaps_on      = 1'b0;
                hold_request = 1'b1;
            end
            burst_left = 0;
            repeat (PHASE_ITEMS) offer_random_number();
            drain_output();
        end

        // Let any stray output appear before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        ledger.check_drained();
        if (ledger.mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
